### rtl/sbs_pkg.sv
`timescale 1ns / 1ps
package sbs_pkg;

    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_IDX_LSB   = 3;
    localparam int CFG_IDX_W     = CFG_ADDR_W - CFG_IDX_LSB;
    localparam int PAT_REG_BYTES = 16;
    localparam int LEN_REG_W     = 5;
    localparam int WORD_BYTES    = 4;
    localparam int OFFSET_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd4;

    typedef struct packed {
        logic [PAT_REG_BYTES*8-1:0] value;
        logic [PAT_REG_BYTES*8-1:0] mask;
        logic [LEN_REG_W-1:0]       length;
    } sbs_cfg_t;

endpackage

### rtl/masked_byte_signature_scanner.sv
`timescale 1ns / 1ps
// Output: a result appears on m_ in the cycle after the word that causes it is accepted.
// Throughput: one word per cycle while s_tready is high; all pattern lanes compare the
// newest aligned candidate in the same cycle. A held result stalls s_ only while
// m_tready is low; it moves out in the same cycle that the next word comes in.
// Reset: synchronous, active low; clears configuration, word count, match flag and the
// output valid. The byte window holds data only and needs no reset.
module masked_byte_signature_scanner #(
    parameter int PATTERN_BYTES     = 16,
    parameter int REGION_WORDS_LOG2 = 30
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sbs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sbs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] region_word
    input  logic                           s_tlast,   // last_word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [31:0] match_offset
    output logic                           m_tuser    // [0] found
);
    import sbs_pkg::*;

    localparam int WB   = PATTERN_BYTES + 4;
    localparam int KMAX = (PATTERN_BYTES + 3) / 4;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int LW   = ($clog2(PATTERN_BYTES + 1) > LEN_REG_W) ?
                          $clog2(PATTERN_BYTES + 1) : LEN_REG_W;
    localparam int RW   = REGION_WORDS_LOG2;

    sbs_cfg_t                 cfg;
    logic [PATTERN_BYTES*8-1:0] win_reg;
    logic [PATTERN_BYTES*8-1:0] win_next;
    logic [WB*8-1:0]          window;
    logic [RW-1:0]            count_reg;
    logic [RW-1:0]            count_next;
    logic                     reported_reg;
    logic                     reported_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_found_reg;
    logic                     out_found_next;
    logic [OFFSET_W-1:0]      out_offset_reg;
    logic [OFFSET_W-1:0]      out_offset_next;
    logic [LW-1:0]            len_raw;
    logic [LW-1:0]            len;
    logic [LW:0]              k_sum;
    logic [KW-1:0]            k;
    logic [RW:0]              w_plus;
    logic [RW:0]              diff;
    logic                     fits;
    logic [PATTERN_BYTES-1:0] lane_ok;
    logic                     hit;
    logic                     emit;
    logic                     accept;

    sbs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    assign window = {s_tdata, win_reg};

    for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_lane
        sbs_lane #(
            .PATTERN_BYTES (PATTERN_BYTES),
            .LANE          (j)
        ) u_lane (
            .window_i (window),
            .k_i      (k),
            .len_i    (len),
            .cfg_i    (cfg),
            .ok_o     (lane_ok[j])
        );
    end

    assign len_raw = LW'(cfg.length);
    assign len     = (len_raw > LW'(PATTERN_BYTES)) ? LW'(PATTERN_BYTES) : len_raw;
    assign k_sum   = {1'b0, len} + (LW+1)'(3);
    assign k       = KW'(k_sum >> 2);
    assign w_plus  = {1'b0, count_reg} + (RW+1)'(1);
    assign fits    = w_plus >= (RW+1)'(k);
    assign diff    = w_plus - (RW+1)'(k);

    assign hit    = !reported_reg && (len != '0) && fits && (&lane_ok);
    assign emit   = hit || (s_tlast && !reported_reg);
    assign accept = s_tvalid && s_tready;

    assign s_tready = !out_valid_reg || m_tready;
    assign win_next = window[WB*8-1:32];

    always_comb begin
        count_next      = count_reg;
        reported_next   = reported_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_offset_next = out_offset_reg;
        if (accept) begin
            if (s_tlast) begin
                count_next    = '0;
                reported_next = 1'b0;
            end else begin
                if (count_reg != '1) begin
                    count_next = count_reg + RW'(1);
                end
                if (hit) begin
                    reported_next = 1'b1;
                end
            end
            if (emit) begin
                out_valid_next  = 1'b1;
                out_found_next  = hit;
                out_offset_next = hit ? OFFSET_W'({diff[RW-1:0], 2'b00}) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_found_reg  <= out_found_next;
        out_offset_reg <= out_offset_next;
        if (accept) begin
            win_reg <= win_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_found_reg;

endmodule

### rtl/sbs_cfg.sv
`timescale 1ns / 1ps
module sbs_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sbs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sbs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sbs_pkg::sbs_cfg_t              cfg_o
);
    import sbs_pkg::*;

    logic [CFG_DATA_W-1:0] value_low_reg;
    logic [CFG_DATA_W-1:0] value_high_reg;
    logic [CFG_DATA_W-1:0] mask_low_reg;
    logic [CFG_DATA_W-1:0] mask_high_reg;
    logic [LEN_REG_W-1:0]  length_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_low_reg  <= '0;
            value_high_reg <= '0;
            mask_low_reg   <= '0;
            mask_high_reg  <= '0;
            length_reg     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_VALUE_LOW:  value_low_reg  <= pwdata;
                REG_VALUE_HIGH: value_high_reg <= pwdata;
                REG_MASK_LOW:   mask_low_reg   <= pwdata;
                REG_MASK_HIGH:  mask_high_reg  <= pwdata;
                REG_LENGTH:     length_reg     <= pwdata[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VALUE_LOW:  prdata = value_low_reg;
            REG_VALUE_HIGH: prdata = value_high_reg;
            REG_MASK_LOW:   prdata = mask_low_reg;
            REG_MASK_HIGH:  prdata = mask_high_reg;
            REG_LENGTH:     prdata = CFG_DATA_W'(length_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg_o.value  = {value_high_reg, value_low_reg};
    assign cfg_o.mask   = {mask_high_reg, mask_low_reg};
    assign cfg_o.length = length_reg;

endmodule

### rtl/sbs_lane.sv
`timescale 1ns / 1ps
module sbs_lane #(
    parameter int PATTERN_BYTES = 16,
    parameter int LANE          = 0,
    localparam int WB   = PATTERN_BYTES + 4,
    localparam int KMAX = (PATTERN_BYTES + 3) / 4,
    localparam int KW   = $clog2(KMAX + 1),
    localparam int LW   = ($clog2(PATTERN_BYTES + 1) > 5) ? $clog2(PATTERN_BYTES + 1) : 5
) (
    input  logic [WB*8-1:0]         window_i,
    input  logic [KW-1:0]           k_i,
    input  logic [LW-1:0]           len_i,
    input  sbs_pkg::sbs_cfg_t       cfg_i,
    output logic                    ok_o
);
    import sbs_pkg::*;

    logic [7:0] cand [KMAX];
    logic [7:0] sel_byte;
    logic       byte_match;
    logic       in_use;

    for (genvar kk = 1; kk <= KMAX; kk++) begin : g_cand
        if (LANE < 4 * kk) begin : g_in
            assign cand[kk-1] = window_i[8*(WB-4*kk+LANE) +: 8];
        end else begin : g_out
            assign cand[kk-1] = '0;
        end
    end

    always_comb begin
        sel_byte = '0;
        for (int kk = 0; kk < KMAX; kk++) begin
            if (k_i == KW'(kk + 1)) begin
                sel_byte = cand[kk];
            end
        end
    end

    if (LANE < PAT_REG_BYTES) begin : g_cmp
        assign byte_match = ((sel_byte ^ cfg_i.value[8*LANE +: 8]) & cfg_i.mask[8*LANE +: 8])
                            == 8'h00;
    end else begin : g_wild
        assign byte_match = 1'b1;
    end

    assign in_use = len_i > LW'(LANE);
    assign ok_o   = !in_use || byte_match;

endmodule
